[src/arpc_pkg.sv]
`default_nettype none
package arpc_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_QUEUE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_LOOKUP    = 3'd0,
    K_QUEUED    = 3'd1,
    K_INSERTED  = 3'd2,
    K_SEND      = 3'd3,
    K_UNREACH   = 3'd4,
    K_TICK_DONE = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    REG_CACHE_TIMEOUT   = 2'd0,
    REG_MAX_SENDS       = 2'd1,
    REG_RESEND_INTERVAL = 2'd2
  } reg_idx_t;

  localparam logic [15:0] TIMEOUT_RST  = 16'd15;
  localparam logic [2:0]  MAX_SENDS_RST = 3'd5;
  localparam logic [7:0]  INTERVAL_RST = 8'd1;
  localparam logic [15:0] AGE_MAX      = 16'hFFFF;
  localparam logic [7:0]  CNT8_MAX     = 8'hFF;

  typedef struct packed {
    op_t         op;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [2:0]  iface;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cache_timeout;
    logic [2:0]  max_sends;
    logic [7:0]  resend_interval;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        hit;
    logic [31:0] found_ip;
    logic [47:0] found_mac;
    logic [2:0]  iface;
    logic [7:0]  waiting;
    logic        full;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

[src/arp_cache_with_request_retry.sv]
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------
// input    | start / busy        | in_opcode in_ip in_mac in_iface
// result   | out_valid strobe    | out_kind out_hit out_found_ip out_found_mac
//          |                     | out_iface out_waiting_packets out_full_res out_last
// config   | cfg_we              | cfg_index cfg_data
//
// lookup, queue and insert go through dequeue, match and execute in turn.
// a tick goes through dequeue, match, cache ageing, a walk of the pending table one slot a cycle, and done.
// a two-beat command queue sits in front, so busy rises only when it is full.
// rst_n clears all valid bits at once; registers return to 15, 5 and 1.
// results come as one-cycle strobes that cannot be held off.
`default_nettype none
module arp_cache_with_request_retry #(
  parameter int CACHE_ENTRIES   = 32,
  parameter int PENDING_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_ip,
  input  wire logic [47:0] in_mac,
  input  wire logic [2:0]  in_iface,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  output logic [2:0]       out_kind,
  output logic             out_hit,
  output logic [31:0]      out_found_ip,
  output logic [47:0]      out_found_mac,
  output logic [2:0]       out_iface,
  output logic [7:0]       out_waiting_packets,
  output logic             out_full_res,
  output logic             out_last
);
  import arpc_pkg::*;

  cfg_t cfg_r;
  cmd_t in_cmd, head_cmd;
  res_t res;
  logic full, head_valid, take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cache_timeout   <= TIMEOUT_RST;
      cfg_r.max_sends       <= MAX_SENDS_RST;
      cfg_r.resend_interval <= INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CACHE_TIMEOUT:   cfg_r.cache_timeout   <= cfg_data;
        REG_MAX_SENDS:       cfg_r.max_sends       <= cfg_data[2:0];
        REG_RESEND_INTERVAL: cfg_r.resend_interval <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_cmd = '{op: op_t'(in_opcode), ip: in_ip, mac: in_mac, iface: in_iface};
  assign busy   = full;

  arpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (start && !full),
    .push_cmd   (in_cmd),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (take)
  );

  arpc_back #(
    .CACHE_ENTRIES   (CACHE_ENTRIES),
    .PENDING_ENTRIES (PENDING_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_take  (take),
    .res       (res)
  );

  assign out_valid           = res.valid;
  assign out_kind            = res.kind;
  assign out_hit             = res.hit;
  assign out_found_ip        = res.found_ip;
  assign out_found_mac       = res.found_mac;
  assign out_iface           = res.iface;
  assign out_waiting_packets = res.waiting;
  assign out_full_res        = res.full;
  assign out_last            = res.last;

  // single-beat commands always close their item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_LOOKUP || out_kind == K_QUEUED || out_kind == K_INSERTED)
    |-> out_last)
    else $error("single result without last");

  a_walk_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_SEND || out_kind == K_UNREACH) |-> !out_last)
    else $error("walk result marked last");

  a_lookup_no_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_LOOKUP |-> !out_full_res)
    else $error("lookup reported full");

endmodule
`default_nettype wire

[src/arpc_front.sv]
`default_nettype none
module arpc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  arpc_pkg::cmd_t     push_cmd,
  output logic               full,
  output logic               head_valid,
  output arpc_pkg::cmd_t     head_cmd,
  input  wire logic          pop
);
  import arpc_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_cmd   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/arpc_back.sv]
`default_nettype none
module arpc_back #(
  parameter int CACHE_ENTRIES   = 32,
  parameter int PENDING_ENTRIES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  arpc_pkg::cfg_t     cfg,
  input  wire logic          cmd_valid,
  input  arpc_pkg::cmd_t     cmd,
  output logic               cmd_take,
  output arpc_pkg::res_t     res
);
  import arpc_pkg::*;

  localparam int CIW = $clog2(CACHE_ENTRIES);
  localparam int PIW = $clog2(PENDING_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_EXEC, S_AGE, S_WALK, S_DONE
  } state_t;

  function automatic logic [CIW-1:0] c_hi(input logic [CACHE_ENTRIES-1:0] v);
    logic [CIW-1:0] r;
    r = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) if (v[i]) r = CIW'(i);
    return r;
  endfunction

  function automatic logic [CIW-1:0] c_lo(input logic [CACHE_ENTRIES-1:0] v);
    logic [CIW-1:0] r;
    r = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) if (v[i]) r = CIW'(i);
    return r;
  endfunction

  function automatic logic [PIW-1:0] p_lo(input logic [PENDING_ENTRIES-1:0] v);
    logic [PIW-1:0] r;
    r = '0;
    for (int i = PENDING_ENTRIES - 1; i >= 0; i--) if (v[i]) r = PIW'(i);
    return r;
  endfunction

  state_t state_r;
  cmd_t   cmd_r;
  res_t   res_r;
  logic [PIW-1:0] widx_r;

  logic [CACHE_ENTRIES-1:0] ent_valid_r;
  logic [31:0] ent_ip_r  [CACHE_ENTRIES];
  logic [47:0] ent_mac_r [CACHE_ENTRIES];
  logic [15:0] ent_age_r [CACHE_ENTRIES];
  logic [15:0] ent_age_inc [CACHE_ENTRIES];

  logic [PENDING_ENTRIES-1:0] pnd_valid_r;
  logic [31:0] pnd_ip_r      [PENDING_ENTRIES];
  logic [2:0]  pnd_iface_r   [PENDING_ENTRIES];
  logic [2:0]  pnd_sends_r   [PENDING_ENTRIES];
  logic [7:0]  pnd_elapsed_r [PENDING_ENTRIES];
  logic [7:0]  pnd_packets_r [PENDING_ENTRIES];

  // match and free vectors, registered in S_MATCH and used in S_EXEC
  logic [CACHE_ENTRIES-1:0]   ent_hit_r, ent_free_r;
  logic [PENDING_ENTRIES-1:0] pnd_hit_r, pnd_free_r;

  logic [CIW-1:0] ent_hit_idx, ent_free_idx;
  logic [PIW-1:0] pnd_hit_idx, pnd_free_idx;
  logic [7:0]     pk_inc, el_inc;

  assign cmd_take     = (state_r == S_IDLE) && cmd_valid;
  assign res          = res_r;
  assign ent_hit_idx  = c_hi(ent_hit_r);
  assign ent_free_idx = c_lo(ent_free_r);
  assign pnd_hit_idx  = p_lo(pnd_hit_r);
  assign pnd_free_idx = p_lo(pnd_free_r);
  assign pk_inc = (pnd_packets_r[pnd_hit_idx] == CNT8_MAX) ? CNT8_MAX
                : pnd_packets_r[pnd_hit_idx] + 8'd1;
  assign el_inc = (pnd_elapsed_r[widx_r] == CNT8_MAX) ? CNT8_MAX
                : pnd_elapsed_r[widx_r] + 8'd1;

  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      ent_age_inc[i] = (ent_age_r[i] == AGE_MAX) ? AGE_MAX : ent_age_r[i] + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    res_t res_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r       <= '0;
      ent_valid_r <= '0;
      pnd_valid_r <= '0;
    end else begin
      res_nxt = '0;
      res_nxt.found_ip = cmd_r.ip;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            state_r <= S_MATCH;
          end
        end
        S_MATCH: begin
          for (int i = 0; i < CACHE_ENTRIES; i++) begin
            ent_hit_r[i]  <= ent_valid_r[i] && (ent_ip_r[i] == cmd_r.ip);
            ent_free_r[i] <= !ent_valid_r[i];
          end
          for (int i = 0; i < PENDING_ENTRIES; i++) begin
            pnd_hit_r[i]  <= pnd_valid_r[i] && (pnd_ip_r[i] == cmd_r.ip);
            pnd_free_r[i] <= !pnd_valid_r[i];
          end
          state_r <= (cmd_r.op == OP_TICK) ? S_AGE : S_EXEC;
        end
        S_EXEC: begin
          res_nxt.valid = 1'b1;
          res_nxt.last  = 1'b1;
          unique case (cmd_r.op)
            OP_LOOKUP: begin
              res_nxt.kind = K_LOOKUP;
              if (|ent_hit_r) begin
                res_nxt.hit       = 1'b1;
                res_nxt.found_mac = ent_mac_r[ent_hit_idx];
              end
            end
            OP_QUEUE: begin
              res_nxt.kind = K_QUEUED;
              priority if (|pnd_hit_r) begin
                pnd_iface_r[pnd_hit_idx]   <= cmd_r.iface;
                pnd_packets_r[pnd_hit_idx] <= pk_inc;
                res_nxt.iface   = cmd_r.iface;
                res_nxt.waiting = pk_inc;
              end else if (|pnd_free_r) begin
                pnd_valid_r[pnd_free_idx]   <= 1'b1;
                pnd_ip_r[pnd_free_idx]      <= cmd_r.ip;
                pnd_iface_r[pnd_free_idx]   <= cmd_r.iface;
                pnd_sends_r[pnd_free_idx]   <= 3'd0;
                pnd_elapsed_r[pnd_free_idx] <= CNT8_MAX;
                pnd_packets_r[pnd_free_idx] <= 8'd1;
                res_nxt.iface   = cmd_r.iface;
                res_nxt.waiting = 8'd1;
              end else begin
                res_nxt.full = 1'b1;
              end
            end
            OP_INSERT: begin
              res_nxt.kind = K_INSERTED;
              if (|pnd_hit_r) begin
                res_nxt.hit     = 1'b1;
                res_nxt.iface   = pnd_iface_r[pnd_hit_idx];
                res_nxt.waiting = pnd_packets_r[pnd_hit_idx];
                pnd_valid_r[pnd_hit_idx] <= 1'b0;
              end
              if (|ent_free_r) begin
                ent_valid_r[ent_free_idx] <= 1'b1;
                ent_ip_r[ent_free_idx]    <= cmd_r.ip;
                ent_mac_r[ent_free_idx]   <= cmd_r.mac;
                ent_age_r[ent_free_idx]   <= 16'd0;
              end else begin
                res_nxt.full = 1'b1;
              end
            end
            default: res_nxt.valid = 1'b0;
          endcase
          state_r <= S_IDLE;
        end
        S_AGE: begin
          for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (ent_valid_r[i]) begin
              ent_age_r[i] <= ent_age_inc[i];
              if (ent_age_inc[i] > cfg.cache_timeout) ent_valid_r[i] <= 1'b0;
            end
          end
          widx_r  <= '0;
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (pnd_valid_r[widx_r]) begin
            priority if (el_inc < cfg.resend_interval) begin
              pnd_elapsed_r[widx_r] <= el_inc;
            end else if (pnd_sends_r[widx_r] >= cfg.max_sends) begin
              pnd_valid_r[widx_r] <= 1'b0;
              res_nxt.valid    = 1'b1;
              res_nxt.kind     = K_UNREACH;
              res_nxt.found_ip = pnd_ip_r[widx_r];
              res_nxt.iface    = pnd_iface_r[widx_r];
              res_nxt.waiting  = pnd_packets_r[widx_r];
            end else begin
              pnd_sends_r[widx_r]   <= pnd_sends_r[widx_r] + 3'd1;
              pnd_elapsed_r[widx_r] <= 8'd0;
              res_nxt.valid    = 1'b1;
              res_nxt.kind     = K_SEND;
              res_nxt.found_ip = pnd_ip_r[widx_r];
              res_nxt.iface    = pnd_iface_r[widx_r];
              res_nxt.waiting  = pnd_packets_r[widx_r];
            end
          end
          if (widx_r == PIW'(PENDING_ENTRIES - 1)) state_r <= S_DONE;
          widx_r <= widx_r + PIW'(1);
        end
        S_DONE: begin
          res_nxt.valid = 1'b1;
          res_nxt.kind  = K_TICK_DONE;
          res_nxt.last  = 1'b1;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

[verif/tb_arp_cache_with_request_retry.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_arp_cache_with_request_retry;
  import arpc_pkg::*;

  localparam int N_CACHE = 32;
  localparam int N_PEND  = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_opcode;
  logic [31:0] in_ip;
  logic [47:0] in_mac;
  logic [2:0]  in_iface;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic        out_hit;
  logic [31:0] out_found_ip;
  logic [47:0] out_found_mac;
  logic [2:0]  out_iface;
  logic [7:0]  out_waiting_packets;
  logic        out_full_res;
  logic        out_last;

  arp_cache_with_request_retry u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_ip(in_ip), .in_mac(in_mac), .in_iface(in_iface),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_kind(out_kind), .out_hit(out_hit),
    .out_found_ip(out_found_ip), .out_found_mac(out_found_mac),
    .out_iface(out_iface), .out_waiting_packets(out_waiting_packets),
    .out_full_res(out_full_res), .out_last(out_last)
  );

  typedef struct {
    kind_t       kind;
    logic        hit;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [2:0]  iface;
    logic [7:0]  pkts;
    logic        full;
    logic        last;
  } arp_res_t;

  typedef struct {
    op_t         op;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [2:0]  iface;
    logic        typed; // expected result given in the row
    arp_res_t    res;
  } stim_row_t;

  // shadow copy of the tables
  logic [15:0] sh_timeout;
  logic [2:0]  sh_max_sends;
  logic [7:0]  sh_interval;
  logic        c_valid [N_CACHE];
  logic [31:0] c_ip    [N_CACHE];
  logic [47:0] c_mac   [N_CACHE];
  logic [15:0] c_age   [N_CACHE];
  logic        p_valid [N_PEND];
  logic [31:0] p_ip    [N_PEND];
  logic [2:0]  p_iface [N_PEND];
  logic [2:0]  p_sends [N_PEND];
  logic [7:0]  p_elap  [N_PEND];
  logic [7:0]  p_pkts  [N_PEND];

  arp_res_t expected_results[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int n_send = 0;
  int n_unreach = 0;
  int n_hits = 0;
  int idle_cycles = 0;

  function automatic arp_res_t mk(kind_t k, logic h, logic [31:0] ip, logic [47:0] m,
                                  logic [2:0] ifc, logic [7:0] pk, logic f, logic l);
    arp_res_t r;
    r.kind = k; r.hit = h; r.ip = ip; r.mac = m;
    r.iface = ifc; r.pkts = pk; r.full = f; r.last = l;
    return r;
  endfunction

  task automatic table_reset();
    sh_timeout = TIMEOUT_RST;
    sh_max_sends = MAX_SENDS_RST;
    sh_interval = INTERVAL_RST;
    for (int i = 0; i < N_CACHE; i++) c_valid[i] = 1'b0;
    for (int i = 0; i < N_PEND; i++) p_valid[i] = 1'b0;
  endtask

  // computes the results of one command and updates the shadow tables
  task automatic arp_predict(op_t op, logic [31:0] ip, logic [47:0] mac, logic [2:0] ifc);
    int p;
    logic h;
    logic [47:0] m;
    logic [2:0] oi;
    logic [7:0] pk;
    logic f;
    p = -1;
    case (op)
      OP_LOOKUP: begin
        h = 1'b0; m = '0;
        for (int i = 0; i < N_CACHE; i++)
          if (c_valid[i] && c_ip[i] == ip) begin
            h = 1'b1; m = c_mac[i];
          end
        expected_results.push_back(mk(K_LOOKUP, h, ip, m, 3'd0, 8'd0, 1'b0, 1'b1));
      end
      OP_QUEUE: begin
        for (int i = 0; i < N_PEND; i++)
          if (p < 0 && p_valid[i] && p_ip[i] == ip) p = i;
        if (p < 0) begin
          for (int i = 0; i < N_PEND; i++)
            if (p < 0 && !p_valid[i]) p = i;
          if (p >= 0) begin
            p_valid[p] = 1'b1; p_ip[p] = ip; p_sends[p] = '0;
            p_elap[p] = CNT8_MAX; p_pkts[p] = '0;
          end
        end
        if (p < 0) begin
          expected_results.push_back(mk(K_QUEUED, 1'b0, ip, '0, 3'd0, 8'd0, 1'b1, 1'b1));
        end else begin
          p_iface[p] = ifc;
          if (p_pkts[p] != CNT8_MAX) p_pkts[p]++;
          expected_results.push_back(mk(K_QUEUED, 1'b0, ip, '0, ifc, p_pkts[p], 1'b0, 1'b1));
        end
      end
      OP_INSERT: begin
        h = 1'b0; oi = '0; pk = '0; f = 1'b1;
        for (int i = 0; i < N_PEND; i++)
          if (p < 0 && p_valid[i] && p_ip[i] == ip) p = i;
        if (p >= 0) begin
          h = 1'b1; oi = p_iface[p]; pk = p_pkts[p]; p_valid[p] = 1'b0;
        end
        for (int i = 0; i < N_CACHE; i++)
          if (f && !c_valid[i]) begin
            c_valid[i] = 1'b1; c_ip[i] = ip; c_mac[i] = mac; c_age[i] = '0; f = 1'b0;
          end
        if (h) n_hits++;
        expected_results.push_back(mk(K_INSERTED, h, ip, '0, oi, pk, f, 1'b1));
      end
      default: begin
        for (int i = 0; i < N_CACHE; i++)
          if (c_valid[i]) begin
            if (c_age[i] != AGE_MAX) c_age[i]++;
            if (c_age[i] > sh_timeout) c_valid[i] = 1'b0;
          end
        for (int i = 0; i < N_PEND; i++)
          if (p_valid[i]) begin
            if (p_elap[i] != CNT8_MAX) p_elap[i]++;
            if (p_elap[i] >= sh_interval) begin
              if (p_sends[i] >= sh_max_sends) begin
                expected_results.push_back(mk(K_UNREACH, 1'b0, p_ip[i], '0, p_iface[i],
                                              p_pkts[i], 1'b0, 1'b0));
                p_valid[i] = 1'b0;
                n_unreach++;
              end else begin
                p_sends[i] = p_sends[i] + 3'd1;
                p_elap[i] = '0;
                expected_results.push_back(mk(K_SEND, 1'b0, p_ip[i], '0, p_iface[i],
                                              p_pkts[i], 1'b0, 1'b0));
                n_send++;
              end
            end
          end
        expected_results.push_back(mk(K_TICK_DONE, 1'b0, ip, '0, 3'd0, 8'd0, 1'b0, 1'b1));
      end
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin
    arp_res_t e;
    if (rst_n && out_valid) begin
      beats_out++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected, kind %0d", out_kind);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_kind != e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_kind); errors++;
        end
        if (out_hit != e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, out_hit); errors++;
        end
        if (out_found_ip != e.ip) begin
          $error("found_ip: expected %h, got %h", e.ip, out_found_ip); errors++;
        end
        if (out_found_mac != e.mac) begin
          $error("found_mac: expected %h, got %h", e.mac, out_found_mac); errors++;
        end
        if (out_iface != e.iface) begin
          $error("out_iface: expected %0d, got %0d", e.iface, out_iface); errors++;
        end
        if (out_waiting_packets != e.pkts) begin
          $error("waiting_packets: expected %0d, got %0d", e.pkts, out_waiting_packets);
          errors++;
        end
        if (out_full_res != e.full) begin
          $error("full_res: expected %0d, got %0d", e.full, out_full_res); errors++;
        end
        if (out_last != e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat either way
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CACHE_TIMEOUT: sh_timeout = val;
      REG_MAX_SENDS:     sh_max_sends = val[2:0];
      default:           sh_interval = val[7:0];
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (N_PEND + 8) @(posedge clk);
  endtask

  // holds start for one beat; keeps it high if the next beat follows at once
  task automatic send_cmd(op_t op, logic [31:0] ip, logic [47:0] mac, logic [2:0] ifc,
                          bit keep);
    start <= 1'b1;
    in_opcode <= op; in_ip <= ip; in_mac <= mac; in_iface <= ifc;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_in++;
    arp_predict(op, ip, mac, ifc);
    if (!keep) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_ip();
    logic [31:0] pool [8];
    pool = '{32'h0A00_0001, 32'h0A00_0002, 32'h0A00_0003, 32'hC0A8_0101,
             32'h0000_0000, 32'hFFFF_FFFF, 32'h7F00_0001, 32'hAC10_0005};
    if ($urandom_range(0, 9) < 8) return pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic random_phase(int count);
    int burst;
    op_t op;
    int r;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (burst == 0) begin
        repeat ($urandom_range(0, 6)) @(posedge clk);
        burst = $urandom_range(1, 12);
      end
      r = $urandom_range(0, 99);
      op = (r < 25) ? OP_LOOKUP : (r < 55) ? OP_QUEUE : (r < 80) ? OP_INSERT : OP_TICK;
      burst--;
      send_cmd(op, pick_ip(), 48'({$urandom(), $urandom()}),
               3'($urandom_range(0, 7)), burst != 0 && k != count - 1);
    end
    start <= 1'b0;
  endtask

  stim_row_t dir_rows[$];

  function automatic stim_row_t row(op_t op, logic [31:0] ip, logic [47:0] mac,
                                    logic [2:0] ifc, bit typed, arp_res_t r);
    stim_row_t s;
    s.op = op; s.ip = ip; s.mac = mac; s.iface = ifc; s.typed = typed; s.res = r;
    return s;
  endfunction

  initial begin
    arp_res_t none;
    arp_res_t got;
    none = mk(K_LOOKUP, 1'b0, 32'h0, 48'h0, 3'd0, 8'd0, 1'b0, 1'b0);
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_opcode = '0; in_ip = '0; in_mac = '0; in_iface = '0;
    table_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: typed rows are read straight off the behaviour
    dir_rows.push_back(row(OP_LOOKUP, 32'hFFFF_FFFF, '0, 3'd0, 1'b1,
                           mk(K_LOOKUP, 1'b0, 32'hFFFF_FFFF, '0, 3'd0, 8'd0, 1'b0, 1'b1)));
    dir_rows.push_back(row(OP_TICK, 32'h0, '0, 3'd0, 1'b1,
                           mk(K_TICK_DONE, 1'b0, 32'h0, '0, 3'd0, 8'd0, 1'b0, 1'b1)));
    dir_rows.push_back(row(OP_QUEUE, 32'h0A00_0001, '0, 3'd7, 1'b1,
                           mk(K_QUEUED, 1'b0, 32'h0A00_0001, '0, 3'd7, 8'd1, 1'b0, 1'b1)));
    dir_rows.push_back(row(OP_QUEUE, 32'h0A00_0001, '0, 3'd2, 1'b0, none));
    dir_rows.push_back(row(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd0, 1'b1,
                           mk(K_INSERTED, 1'b0, 32'hFFFF_FFFF, '0, 3'd0, 8'd0, 1'b0, 1'b1)));
    dir_rows.push_back(row(OP_LOOKUP, 32'hFFFF_FFFF, '0, 3'd0, 1'b1,
                           mk(K_LOOKUP, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd0,
                              8'd0, 1'b0, 1'b1)));
    dir_rows.push_back(row(OP_INSERT, 32'hFFFF_FFFF, 48'h0000_0000_0001, 3'd0, 1'b0, none));
    dir_rows.push_back(row(OP_LOOKUP, 32'hFFFF_FFFF, '0, 3'd0, 1'b0, none));
    dir_rows.push_back(row(OP_TICK, 32'h1234_5678, '0, 3'd0, 1'b0, none));
    dir_rows.push_back(row(OP_TICK, 32'h0, '0, 3'd0, 1'b0, none));
    dir_rows.push_back(row(OP_INSERT, 32'h0A00_0001, 48'hAAAA_5555_0000, 3'd0, 1'b0, none));
    dir_rows.push_back(row(OP_INSERT, 32'h0000_0000, 48'h0, 3'd0, 1'b0, none));
    dir_rows.push_back(row(OP_LOOKUP, 32'h0000_0000, '0, 3'd0, 1'b0, none));
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].op, dir_rows[i].ip, dir_rows[i].mac, dir_rows[i].iface, 0);
      if (dir_rows[i].typed) begin
        got = expected_results[$];
        if (got != dir_rows[i].res) begin
          $error("directed row %0d: predictor disagrees with typed result", i);
          errors++;
        end
      end
    end
    drain();

    // saturate the waiting count, then fill the pending table
    for (int k = 0; k < 256; k++) send_cmd(OP_QUEUE, 32'hC0A8_0101, '0, 3'd5, k != 255);
    for (int k = 0; k < 17; k++) send_cmd(OP_QUEUE, 32'h0B00_0000 + k, '0, 3'd1, k != 16);
    drain();

    // extremes of the registers
    cfg_write(REG_MAX_SENDS, 16'd0);
    cfg_write(REG_RESEND_INTERVAL, 16'd0);
    cfg_write(REG_CACHE_TIMEOUT, 16'hFFFF);
    send_cmd(OP_TICK, 32'h0, '0, 3'd0, 0);
    for (int k = 0; k < 34; k++)
      send_cmd(OP_INSERT, 32'h0C00_0000 + k, {16'h0, 32'h0C00_0000 + k}, 3'd0, k != 33);
    drain();

    cfg_write(REG_CACHE_TIMEOUT, 16'd1);
    cfg_write(REG_MAX_SENDS, 16'd7);
    cfg_write(REG_RESEND_INTERVAL, 16'd255);
    random_phase(30);
    drain();

    cfg_write(REG_CACHE_TIMEOUT, 16'd3);
    cfg_write(REG_MAX_SENDS, 16'd2);
    cfg_write(REG_RESEND_INTERVAL, 16'd2);
    random_phase(30);
    drain();

    cfg_write(REG_CACHE_TIMEOUT, 16'd15);
    cfg_write(REG_MAX_SENDS, 16'd1);
    cfg_write(REG_RESEND_INTERVAL, 16'd1);
    random_phase(30);
    drain();

    $display("%0d commands, %0d result beats, %0d resends, %0d abandoned, %0d resolved",
             beats_in, beats_out, n_send, n_unreach, n_hits);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (expected_results.size() != 0)
        $error("%0d expected results never arrived", expected_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
